// File: rtl/bmct_pkg.sv
// shared types, codes and helpers for the bracket matching command tokeniser
package bmct_pkg;

  localparam int unsigned POS_W       = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_INCPTR  = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_DECPTR  = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_INCDATA = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_DECDATA = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_OUTPUT  = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_INPUT   = 8'h2C;  // ','
  localparam logic [7:0] CHAR_LOOPBEG = 8'h5B;  // '['
  localparam logic [7:0] CHAR_LOOPEND = 8'h5D;  // ']'

  typedef enum logic [1:0] {
    REC_CMD    = 2'd0,
    REC_PATCH  = 2'd1,
    REC_STATUS = 2'd2
  } record_e;

  typedef enum logic [2:0] {
    OP_INCPTR  = 3'd0,
    OP_DECPTR  = 3'd1,
    OP_INCDATA = 3'd2,
    OP_DECDATA = 3'd3,
    OP_OUTPUT  = 3'd4,
    OP_INPUT   = 3'd5,
    OP_LOOPBEG = 3'd6,
    OP_LOOPEND = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXTRA_CLOSE = 3'd1,
    ST_UNCLOSED    = 3'd2,
    ST_NEST_OVF    = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_e;

  // classified character
  typedef struct packed {
    logic is_cmd;
    op_e  op;
  } class_t;

  // work descriptor for one transaction, up to three records
  typedef struct packed {
    logic             has_cmd;
    logic             has_patch;
    logic             has_status;
    op_e              op;
    logic [POS_W-1:0] cmd_pos;
    logic [POS_W-1:0] start_pos;
    status_e          status;
    logic [POS_W-1:0] status_pos;
  } desc_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    r.is_cmd = 1'b1;
    r.op     = OP_INCPTR;
    case (c)
      CHAR_INCPTR:  r.op = OP_INCPTR;
      CHAR_DECPTR:  r.op = OP_DECPTR;
      CHAR_INCDATA: r.op = OP_INCDATA;
      CHAR_DECDATA: r.op = OP_DECDATA;
      CHAR_OUTPUT:  r.op = OP_OUTPUT;
      CHAR_INPUT:   r.op = OP_INPUT;
      CHAR_LOOPBEG: r.op = OP_LOOPBEG;
      CHAR_LOOPEND: r.op = OP_LOOPEND;
      default:      r.is_cmd = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/bmct_if.sv
// valid/ready channel interfaces for source characters and result records
interface bmct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final;
  modport source (output valid, output char_code, output is_final, input ready);
  modport sink (input valid, input char_code, input is_final, output ready);
endinterface

interface bmct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_type;
  logic [2:0]  op_kind;
  logic [15:0] cmd_pos;
  logic [15:0] partner_pos;
  logic [2:0]  status;
  logic        last_of_run;
  modport source (output valid, output record_type, output op_kind, output cmd_pos,
                  output partner_pos, output status, output last_of_run, input ready);
  modport sink (input valid, input record_type, input op_kind, input cmd_pos,
                input partner_pos, input status, input last_of_run, output ready);
endinterface

// File: rtl/bmct_front.sv
// front end: classifies characters, runs the bracket stack and command counter
module bmct_front #(
  parameter int unsigned NEST_DEPTH   = 64,
  parameter int unsigned MAX_COMMANDS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bmct_in_if.sink         in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output bmct_pkg::desc_t q_desc_o
);
  import bmct_pkg::*;

  localparam int unsigned LVL_W  = $clog2(NEST_DEPTH + 1);
  localparam int unsigned ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_COMMANDS + 1);

  logic [LVL_W-1:0] level_q, level_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             halted_q, halted_d;
  logic [POS_W-1:0] top_q, top_d;
  logic [POS_W-1:0] below_q;

  // entries below the top of stack; the top lives in top_q
  logic [POS_W-1:0] stack_mem [NEST_DEPTH];

  logic             fire;
  logic             mem_we;
  logic [LVL_W-1:0] wr_lvl, rd_lvl;
  logic [POS_W-1:0] cnt_pos;
  logic             err;
  class_t           cls;
  desc_t            desc;

  assign in_i.ready = halted_q || !q_full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign cls        = classify(in_i.char_code);
  assign cnt_pos    = POS_W'(count_q);
  assign wr_lvl     = level_q - LVL_W'(1);
  assign rd_lvl     = level_d - LVL_W'(2);

  always_comb begin
    level_d  = level_q;
    count_d  = count_q;
    halted_d = halted_q;
    top_d    = top_q;
    mem_we   = 1'b0;
    err      = 1'b0;
    desc     = '0;
    desc.op  = cls.op;
    desc.cmd_pos = cnt_pos;
    if (fire && !halted_q) begin
      if (cls.is_cmd) begin
        if (count_q == CNT_W'(MAX_COMMANDS)) begin
          err         = 1'b1;
          desc.status = ST_TOO_LONG;
        end else if (cls.op == OP_LOOPBEG) begin
          if (level_q == LVL_W'(NEST_DEPTH)) begin
            err         = 1'b1;
            desc.status = ST_NEST_OVF;
          end else begin
            mem_we       = (level_q != '0);
            top_d        = cnt_pos;
            level_d      = level_q + LVL_W'(1);
            count_d      = count_q + CNT_W'(1);
            desc.has_cmd = 1'b1;
          end
        end else if (cls.op == OP_LOOPEND) begin
          if (level_q == '0) begin
            err         = 1'b1;
            desc.status = ST_EXTRA_CLOSE;
          end else begin
            desc.start_pos = top_q;
            top_d          = below_q;
            level_d        = level_q - LVL_W'(1);
            count_d        = count_q + CNT_W'(1);
            desc.has_cmd   = 1'b1;
            desc.has_patch = 1'b1;
          end
        end else begin
          count_d      = count_q + CNT_W'(1);
          desc.has_cmd = 1'b1;
        end
      end
      if (err) begin
        desc.has_status = 1'b1;
        desc.status_pos = cnt_pos;
        halted_d        = 1'b1;
      end else if (in_i.is_final) begin
        desc.has_status = 1'b1;
        halted_d        = 1'b1;
        if (level_d != '0) begin
          desc.status     = ST_UNCLOSED;
          desc.status_pos = top_d;
        end else begin
          desc.status     = ST_OK;
          desc.status_pos = '0;
        end
      end
    end
  end

  assign q_push_o = desc.has_cmd || desc.has_status;
  assign q_desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      level_q  <= level_d;
      count_q  <= count_d;
      halted_q <= halted_d;
    end
  end

  // stack store with registered read of the entry under the next top
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (mem_we) begin
      stack_mem[wr_lvl[ADDR_W-1:0]] <= top_q;
    end
    if (mem_we && (wr_lvl == rd_lvl)) begin
      below_q <= top_q;
    end else begin
      below_q <= stack_mem[rd_lvl[ADDR_W-1:0]];
    end
  end

endmodule

// File: rtl/bmct_queue.sv
// small descriptor queue between the front end and the record sequencer
module bmct_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bmct_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bmct_pkg::desc_t head_o
);
  import bmct_pkg::*;

  desc_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// File: rtl/bmct_back.sv
// back end: expands each descriptor into records on a registered output
module bmct_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  bmct_pkg::desc_t q_head_i,
  output logic            q_pop_o,
  bmct_out_if.source      out_o
);
  import bmct_pkg::*;

  logic [2:0]       done_q, done_d;
  logic [2:0]       remain, cur;
  logic             last, load;
  logic             valid_q;
  record_e          type_q;
  op_e              op_q;
  logic [POS_W-1:0] pos_q, partner_q;
  status_e          status_q;
  logic             last_q;

  // bit 0 command record, bit 1 patch record, bit 2 status record
  assign remain  = {q_head_i.has_status, q_head_i.has_patch, q_head_i.has_cmd} & ~done_q;
  assign cur     = remain & (~remain + 3'd1);
  assign last    = ((remain & ~cur) == 3'b000);
  assign load    = !q_empty_i && (!valid_q || out_o.ready);
  assign q_pop_o = load && last;
  assign done_d  = load ? (last ? 3'b000 : (done_q | cur)) : done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 3'b000;
    end else begin
      done_q <= done_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= last;
      if (cur[0]) begin
        type_q    <= REC_CMD;
        op_q      <= q_head_i.op;
        pos_q     <= q_head_i.cmd_pos;
        partner_q <= (q_head_i.op == OP_LOOPEND) ? q_head_i.start_pos : '0;
        status_q  <= ST_OK;
      end else if (cur[1]) begin
        type_q    <= REC_PATCH;
        op_q      <= OP_LOOPBEG;
        pos_q     <= q_head_i.start_pos;
        partner_q <= q_head_i.cmd_pos;
        status_q  <= ST_OK;
      end else begin
        type_q    <= REC_STATUS;
        op_q      <= OP_INCPTR;
        pos_q     <= q_head_i.status_pos;
        partner_q <= '0;
        status_q  <= q_head_i.status;
      end
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.record_type = type_q;
  assign out_o.op_kind     = op_q;
  assign out_o.cmd_pos     = pos_q;
  assign out_o.partner_pos = partner_q;
  assign out_o.status      = status_q;
  assign out_o.last_of_run = last_q;

endmodule

// File: rtl/bracket_matching_command_tokenizer_unit.sv
// top level of the bracket matching command tokeniser
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    char_code[7:0], is_final
//   out_o    out  valid / ready    record_type, op_kind, cmd_pos, partner_pos,
//                                  status, last_of_run
//
// one character transaction per cycle while the queue has room; the front end
// pushes or pops the stack and bumps the counter in the accepting cycle
// records pass the queue and output register, then one per cycle while out_o
// is ready: a matched close bracket gives two, a final character or an error
// adds a status record; the four-entry queue stalls the input only when full;
// once halted all input is taken and dropped; reset spares stack and data regs
module bracket_matching_command_tokenizer_unit #(
  parameter int unsigned NEST_DEPTH   = 64,
  parameter int unsigned MAX_COMMANDS = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmct_in_if.sink    in_i,
  bmct_out_if.source out_o
);
  import bmct_pkg::*;

  // descriptor hand-off between front end and back end
  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_push_desc, q_head;

  // classify, stack and counter
  bmct_front #(
    .NEST_DEPTH   (NEST_DEPTH),
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_desc_o (q_push_desc)
  );

  // decoupling queue
  bmct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (q_push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // record sequencer with output register
  bmct_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
